// File: rtl/ttip_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the text-to-integer parser.
// Used by the front stage, the queue, the back stage and the top level; depends on nothing.

package ttip_pkg;

	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 16;
	localparam int CHAR_BITS  = 8;
	localparam int BASE_BITS  = 5;
	localparam int CFG_IDX_BITS = 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_BITS-1:0] REG_BASE_SELECT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIGNED_MODE = 1'd1;

	localparam logic [BASE_BITS-1:0] BASE_AUTO = 5'd0;
	localparam logic [BASE_BITS-1:0] BASE_OCT  = 5'd8;
	localparam logic [BASE_BITS-1:0] BASE_DEC  = 5'd10;
	localparam logic [BASE_BITS-1:0] BASE_HEX  = 5'd16;

	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_BITS-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_BITS-1:0] CASE_BIT = 8'h20;
	localparam logic [CHAR_BITS-1:0] HEX_OFS  = 8'h57;

	typedef struct packed {
		logic       first;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       is_hex;
		logic [3:0] dig;
	} class_t;

	function automatic class_t classify(input logic [CHAR_BITS-1:0] c, input logic f);
		class_t r;
		logic [CHAR_BITS-1:0] lc;
		logic [CHAR_BITS-1:0] d;
		lc = c | CASE_BIT;
		r.first    = f;
		r.is_minus = (c == CH_MINUS);
		r.is_zero  = (c == CH_ZERO);
		r.is_x     = (lc == CH_LX);
		r.is_hex   = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
			(c >= CH_UA && c <= CH_UF);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else begin
			d = lc - HEX_OFS;
		end
		r.dig = d[3:0];
		return r;
	endfunction

	function automatic logic [COUNT_BITS-1:0] count_add(input logic [COUNT_BITS-1:0] c,
			input logic [1:0] n);
		logic [COUNT_BITS:0] s;
		s = {1'b0, c} + {{(COUNT_BITS-1){1'b0}}, n};
		return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
	endfunction

endpackage

// File: rtl/ttip_front.sv
`timescale 1ns / 1ps
// Front stage: accepts characters, classifies them and registers the class.
// Depends on ttip_pkg.

module ttip_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ttip_pkg::CHAR_BITS-1:0]     ch,
	input  logic                               first,
	output logic                               push,
	output ttip_pkg::class_t                   push_data,
	input  logic                               full
);

	logic             valid_s1;
	ttip_pkg::class_t class_s1;

	assign push      = valid_s1 && !full;
	assign push_data = class_s1;
	assign in_ready  = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			class_s1 <= ttip_pkg::classify(ch, first);
		end
	end

endmodule

// File: rtl/ttip_queue.sv
`timescale 1ns / 1ps
// Short queue of classified characters between the front and back stages.
// Depends on ttip_pkg.

module ttip_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ttip_pkg::class_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output ttip_pkg::class_t pop_data
);

	ttip_pkg::class_t                     entry_q [ttip_pkg::QUEUE_DEPTH];
	logic [ttip_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_q;
	logic [ttip_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_q;
	logic [ttip_pkg::QUEUE_PTR_BITS:0]    count_q;

	assign full     = (count_q == (ttip_pkg::QUEUE_PTR_BITS+1)'(ttip_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/ttip_back.sv
`timescale 1ns / 1ps
// Back stage: runs the parse state machine, accumulates digits, registers results.
// Depends on ttip_pkg.

module ttip_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ttip_pkg::BASE_BITS-1:0]    base_select,
	input  logic                              signed_mode,
	input  logic                              empty,
	input  ttip_pkg::class_t                  pop_data,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ttip_pkg::VALUE_BITS-1:0]   value,
	output logic [ttip_pkg::COUNT_BITS-1:0]   end_offset
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_START  = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_ZEROX  = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	logic [2:0]                           phase_q;
	logic [ttip_pkg::VALUE_BITS-1:0]      acc_q;
	logic [ttip_pkg::COUNT_BITS-1:0]      cnt_q;
	logic [ttip_pkg::BASE_BITS-1:0]       base_q;
	logic                                 minus_q;
	logic                                 out_valid_q;
	logic [ttip_pkg::VALUE_BITS-1:0]      value_q;
	logic [ttip_pkg::COUNT_BITS-1:0]      end_offset_q;

	logic [2:0]                           n_ph;
	logic [ttip_pkg::VALUE_BITS-1:0]      n_acc;
	logic [ttip_pkg::COUNT_BITS-1:0]      n_cnt;
	logic [ttip_pkg::BASE_BITS-1:0]       n_base;
	logic                                 n_minus;
	logic                                 do_step;
	logic                                 from_start;
	logic                                 fin;
	logic [ttip_pkg::VALUE_BITS-1:0]      fin_val;
	logic [ttip_pkg::COUNT_BITS-1:0]      fin_cnt;
	logic [ttip_pkg::VALUE_BITS-1:0]      prod;
	logic [ttip_pkg::VALUE_BITS-1:0]      res_val;
	ttip_pkg::class_t                     e;

	assign e         = pop_data;
	assign pop       = !empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign end_offset = end_offset_q;

	always_comb begin
		n_ph       = phase_q;
		n_acc      = acc_q;
		n_cnt      = cnt_q;
		n_base     = base_q;
		n_minus    = minus_q;
		do_step    = 1'b0;
		from_start = 1'b0;
		fin        = 1'b0;
		fin_val    = '0;
		fin_cnt    = '0;
		prod       = '0;
		if (e.first) begin
			n_ph    = PH_START;
			n_acc   = '0;
			n_cnt   = '0;
			n_base  = base_select;
			n_minus = 1'b0;
		end
		unique case (n_ph)
			PH_START: begin
				if (signed_mode && e.is_minus && !n_minus) begin
					n_minus = 1'b1;
					n_cnt   = ttip_pkg::count_add(n_cnt, 2'd1);
				end else if (e.is_zero &&
						(n_base == ttip_pkg::BASE_AUTO || n_base == ttip_pkg::BASE_HEX)) begin
					n_cnt = ttip_pkg::count_add(n_cnt, 2'd1);
					n_ph  = PH_ZERO;
				end else begin
					if (n_base == ttip_pkg::BASE_AUTO) begin
						n_base = ttip_pkg::BASE_DEC;
					end
					do_step    = 1'b1;
					from_start = 1'b1;
				end
			end
			PH_ZERO: begin
				if (e.is_x) begin
					n_ph = PH_ZEROX;
				end else begin
					if (n_base == ttip_pkg::BASE_AUTO) begin
						n_base = ttip_pkg::BASE_OCT;
					end
					n_ph    = PH_DIGITS;
					do_step = 1'b1;
				end
			end
			PH_ZEROX: begin
				if (e.is_hex) begin
					n_base = ttip_pkg::BASE_HEX;
					n_acc  = ttip_pkg::VALUE_BITS'(e.dig);
					n_cnt  = ttip_pkg::count_add(n_cnt, 2'd2);
					n_ph   = PH_DIGITS;
				end else begin
					fin     = 1'b1;
					fin_cnt = n_cnt;
				end
			end
			PH_DIGITS: begin
				do_step = 1'b1;
			end
			default: begin
				n_ph = phase_q;
			end
		endcase
		if (do_step) begin
			if (e.is_hex && ttip_pkg::BASE_BITS'(e.dig) < n_base) begin
				prod  = n_acc * ttip_pkg::VALUE_BITS'(n_base);
				n_acc = prod + ttip_pkg::VALUE_BITS'(e.dig);
				n_cnt = ttip_pkg::count_add(n_cnt, 2'd1);
				n_ph  = PH_DIGITS;
			end else begin
				fin = 1'b1;
				if (!from_start) begin
					fin_val = n_acc;
					fin_cnt = n_cnt;
				end
			end
		end
		if (fin) begin
			n_ph = PH_IDLE;
		end
		res_val = n_minus ? (ttip_pkg::VALUE_BITS'(0) - fin_val) : fin_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			acc_q       <= '0;
			cnt_q       <= '0;
			base_q      <= '0;
			minus_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			phase_q     <= n_ph;
			acc_q       <= n_acc;
			cnt_q       <= n_cnt;
			base_q      <= n_base;
			minus_q     <= n_minus;
			out_valid_q <= fin;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && fin) begin
			value_q      <= res_val;
			end_offset_q <= fin_cnt;
		end
	end

endmodule

// File: rtl/text_to_integer_parser.sv
`timescale 1ns / 1ps
// Top level of the streaming text-to-integer parser: configuration registers,
// front stage, queue and back stage. Depends on ttip_pkg, ttip_front, ttip_queue, ttip_back.

// Takes one character per cycle while in_ready is high, in the manner of
// strtoul/strtol, and gives one result (value, characters consumed) at the first
// character that is not a valid digit; characters after that are dropped until
// one marked first arrives. A character passes the input register, a four-entry
// queue and the back stage's multiply-add (value*base+digit with the phase
// update), where out_valid is registered with the phase; that multiply-add loop
// sets the sustained rate of one character per cycle unless a result waits on out_ready.

module text_to_integer_parser (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ttip_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [ttip_pkg::BASE_BITS-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ttip_pkg::CHAR_BITS-1:0]        ch,
	input  logic                                  first,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [ttip_pkg::VALUE_BITS-1:0]       value,
	output logic [ttip_pkg::COUNT_BITS-1:0]       end_offset
);

	logic [ttip_pkg::BASE_BITS-1:0] base_select_q;
	logic                           signed_mode_q;
	logic                           push;
	logic                           full;
	logic                           pop;
	logic                           empty;
	ttip_pkg::class_t               push_data;
	ttip_pkg::class_t               pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_select_q <= '0;
			signed_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ttip_pkg::REG_BASE_SELECT: base_select_q <= cfg_data;
				ttip_pkg::REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: base_select_q <= base_select_q;
			endcase
		end
	end

	ttip_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.first     (first),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	ttip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	ttip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_select (base_select_q),
		.signed_mode (signed_mode_q),
		.empty       (empty),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.end_offset  (end_offset)
	);

endmodule
